>>> sv/dfs_timestamps_adjacency_matrix_defines.svh
// Assertion macros shared by the checker of the depth-first search block.
// No dependencies; included by files that hold concurrent assertions.
`ifndef DFS_TIMESTAMPS_ADJACENCY_MATRIX_DEFINES_SVH
`define DFS_TIMESTAMPS_ADJACENCY_MATRIX_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define DFSTA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define DFSTA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> sv/dfsta_pkg.sv
// Package of the depth-first search block: sizes, codes and the structs
// exchanged between controller and datapath. No dependencies.
package dfsta_pkg;

    // Graph size and field widths.
    localparam int NODES     = 8;
    localparam int VIDX_W    = 3;
    localparam int POS_W     = 4;
    localparam int TIME_W    = 5;
    localparam int ROW_W     = 8;
    localparam int S_FIELD_W = VIDX_W + ROW_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W = VIDX_W + 1 + VIDX_W + TIME_W + TIME_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // Scan position one past the last neighbor, and the final vertex index.
    localparam logic [POS_W-1:0]  POS_END     = POS_W'(NODES);
    localparam logic [VIDX_W-1:0] LAST_VERTEX = VIDX_W'(NODES - 1);

    // Function codes carried in s_tuser.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    typedef enum logic [1:0] {
        CLR_WHITE = 2'd0,
        CLR_GREY  = 2'd1,
        CLR_BLACK = 2'd2
    } colour_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear;
        logic root;
        logic scan;
        logic emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic roots_done;
        logic root_white;
        logic pop_last;
        logic emit_last;
    } dp_sts_t;

endpackage

>>> sv/dfs_timestamps_adjacency_matrix.sv
// Channel   | Direction | Contents
// s_ (in)   | slave     | tuser: func; tdata: row_index, row_bits
// m_ (out)  | master    | tdata: vertex, has_parent, parent, discover_time, finish_time; tlast
//
// A load writes one adjacency row. A run steps through the root and scan states, with
// one adjacency test per cycle in the scan loop, then emits NODES results.
// Reset (aresetn, synchronous) empties the stack and drops any pending result.
// While a run is busy s_tready is low; a stalled result waits in the output
// register while the next input transaction is already accepted.
// Top level of the depth-first search block; depends on dfsta_pkg,
// dfsta_ctrl and dfsta_dp.
module dfs_timestamps_adjacency_matrix (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dfsta_pkg::S_TDATA_W-1:0] s_tdata,   // row_index[2:0], row_bits[10:3]
    input  logic                            s_tuser,   // func[0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dfsta_pkg::M_TDATA_W-1:0] m_tdata,   // vertex[2:0], has_parent[3],
                                                       // parent[6:4], discover_time[11:7],
                                                       // finish_time[16:12]
    output logic                            m_tlast    // last
);

    dfsta_pkg::dp_cmd_t cmd;
    dfsta_pkg::dp_sts_t sts;

    // Sequencing.
    dfsta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Storage and search datapath.
    dfsta_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .load_row  (s_tdata[dfsta_pkg::VIDX_W-1:0]),
        .load_bits (s_tdata[dfsta_pkg::S_FIELD_W-1:dfsta_pkg::VIDX_W]),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> sv/dfsta_dp.sv
// Datapath of the depth-first search block: adjacency rows, vertex tables,
// visit stack, time counter and the result register. Depends on dfsta_pkg.
module dfsta_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dfsta_pkg::dp_cmd_t                  cmd,
    input  logic [dfsta_pkg::VIDX_W-1:0]        load_row,
    input  logic [dfsta_pkg::ROW_W-1:0]         load_bits,
    output dfsta_pkg::dp_sts_t                  sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dfsta_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);

    // Graph and per-vertex tables.
    logic [dfsta_pkg::ROW_W-1:0]   adj_reg   [dfsta_pkg::NODES];
    dfsta_pkg::colour_t            colour_reg[dfsta_pkg::NODES];
    logic [dfsta_pkg::VIDX_W-1:0]  par_reg   [dfsta_pkg::NODES];
    logic                          pvld_reg  [dfsta_pkg::NODES];
    logic [dfsta_pkg::TIME_W-1:0]  disc_reg  [dfsta_pkg::NODES];
    logic [dfsta_pkg::TIME_W-1:0]  fin_reg   [dfsta_pkg::NODES];

    // Visit stack: vertex and next scan position per entry.
    logic [dfsta_pkg::VIDX_W-1:0]  stk_v_reg [dfsta_pkg::NODES];
    logic [dfsta_pkg::POS_W-1:0]   stk_p_reg [dfsta_pkg::NODES];

    logic [dfsta_pkg::POS_W-1:0]   depth_reg, depth_next;
    logic [dfsta_pkg::POS_W-1:0]   root_reg, root_next;
    logic [dfsta_pkg::TIME_W-1:0]  time_reg, time_next;
    logic [dfsta_pkg::VIDX_W-1:0]  emit_reg, emit_next;
    logic                          out_valid_reg, out_valid_next;
    logic [dfsta_pkg::M_TDATA_W-1:0] out_data_reg;
    logic                          out_last_reg;

    logic [dfsta_pkg::VIDX_W-1:0]  top;
    logic [dfsta_pkg::VIDX_W-1:0]  cur_v;
    logic [dfsta_pkg::POS_W-1:0]   cur_m;
    logic [dfsta_pkg::VIDX_W-1:0]  cur_mi;
    logic [dfsta_pkg::VIDX_W-1:0]  root_i;
    logic [dfsta_pkg::VIDX_W-1:0]  push_slot;
    logic [dfsta_pkg::TIME_W-1:0]  time_inc;
    logic                          scan_end;
    logic                          edge_hit;
    logic                          push_root, push_scan, advance, pop, emit_fire;

    // Decode of the current stack top and the neighbor under test.
    always_comb begin
        top       = depth_reg[dfsta_pkg::VIDX_W-1:0] - 3'd1;
        push_slot = depth_reg[dfsta_pkg::VIDX_W-1:0];
        cur_v     = stk_v_reg[top];
        cur_m     = stk_p_reg[top];
        cur_mi    = cur_m[dfsta_pkg::VIDX_W-1:0];
        root_i    = root_reg[dfsta_pkg::VIDX_W-1:0];
        scan_end  = (cur_m == dfsta_pkg::POS_END);
        edge_hit  = !scan_end && adj_reg[cur_v][cur_mi] &&
                    (colour_reg[cur_mi] == dfsta_pkg::CLR_WHITE);
        time_inc  = time_reg + 5'd1;

        sts.roots_done = (root_reg == dfsta_pkg::POS_END);
        sts.root_white = (colour_reg[root_i] == dfsta_pkg::CLR_WHITE);

        push_root = cmd.root && !sts.roots_done && sts.root_white;
        push_scan = cmd.scan && edge_hit;
        advance   = cmd.scan && !scan_end && !edge_hit;
        pop       = cmd.scan && scan_end;
        emit_fire = cmd.emit && (!out_valid_reg || m_tready);

        sts.pop_last  = pop && (depth_reg == 4'd1);
        sts.emit_last = emit_fire && (emit_reg == dfsta_pkg::LAST_VERTEX);
    end

    // Next values of the search and output control state.
    always_comb begin
        depth_next     = depth_reg;
        root_next      = root_reg;
        time_next      = time_reg;
        emit_next      = emit_reg;
        out_valid_next = out_valid_reg;
        if (cmd.clear) begin
            depth_next = '0;
            root_next  = '0;
            time_next  = '0;
            emit_next  = '0;
        end
        if (cmd.root && !sts.roots_done) begin
            root_next = root_reg + 4'd1;
        end
        if (push_root) begin
            depth_next = 4'd1;
        end
        if (push_scan) begin
            depth_next = depth_reg + 4'd1;
        end
        if (pop) begin
            depth_next = depth_reg - 4'd1;
        end
        if (push_root || push_scan || pop) begin
            time_next = time_inc;
        end
        if (emit_fire) begin
            emit_next      = emit_reg + 3'd1;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= '0;
            root_reg      <= '0;
            time_reg      <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            depth_reg     <= depth_next;
            root_reg      <= root_next;
            time_reg      <= time_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Tables, stack and result payload; every run clears the per-vertex tables first.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            adj_reg[load_row] <= load_bits;
        end
        if (cmd.clear) begin
            for (int i = 0; i < dfsta_pkg::NODES; i++) begin
                colour_reg[i] <= dfsta_pkg::CLR_WHITE;
                par_reg[i]    <= '0;
                pvld_reg[i]   <= 1'b0;
                disc_reg[i]   <= '0;
                fin_reg[i]    <= '0;
            end
        end
        if (push_root) begin
            colour_reg[root_i] <= dfsta_pkg::CLR_GREY;
            disc_reg[root_i]   <= time_inc;
            stk_v_reg[0]       <= root_i;
            stk_p_reg[0]       <= '0;
        end
        if (push_scan) begin
            stk_p_reg[top]        <= cur_m + 4'd1;
            par_reg[cur_mi]       <= cur_v;
            pvld_reg[cur_mi]      <= 1'b1;
            disc_reg[cur_mi]      <= time_inc;
            colour_reg[cur_mi]    <= dfsta_pkg::CLR_GREY;
            stk_v_reg[push_slot]  <= cur_mi;
            stk_p_reg[push_slot]  <= '0;
        end
        if (advance) begin
            stk_p_reg[top] <= cur_m + 4'd1;
        end
        if (pop) begin
            colour_reg[cur_v] <= dfsta_pkg::CLR_BLACK;
            fin_reg[cur_v]    <= time_inc;
        end
        if (emit_fire) begin
            out_data_reg <= {{(dfsta_pkg::M_TDATA_W - dfsta_pkg::M_FIELD_W){1'b0}},
                             fin_reg[emit_reg], disc_reg[emit_reg],
                             par_reg[emit_reg], pvld_reg[emit_reg], emit_reg};
            out_last_reg <= (emit_reg == dfsta_pkg::LAST_VERTEX);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> sv/dfsta_ctrl.sv
// Controller of the depth-first search block: accepts input transactions and
// sequences root selection, neighbor scan and result output. Uses dfsta_pkg.
module dfsta_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_tuser,
    input  dfsta_pkg::dp_sts_t sts,
    output dfsta_pkg::dp_cmd_t cmd
);

    dfsta_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dfsta_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            dfsta_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == dfsta_pkg::FUNC_RUN) begin
                        cmd.clear  = 1'b1;
                        state_next = dfsta_pkg::ST_ROOT;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            dfsta_pkg::ST_ROOT: begin
                cmd.root = 1'b1;
                if (sts.roots_done) begin
                    state_next = dfsta_pkg::ST_EMIT;
                end else if (sts.root_white) begin
                    state_next = dfsta_pkg::ST_SCAN;
                end
            end
            dfsta_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.pop_last) begin
                    state_next = dfsta_pkg::ST_ROOT;
                end
            end
            dfsta_pkg::ST_EMIT: begin
                cmd.emit = 1'b1;
                if (sts.emit_last) begin
                    state_next = dfsta_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dfsta_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/dfsta_checker.sv
// Port-level checker of the depth-first search block and its bind statement.
// Depends on dfsta_pkg and dfs_timestamps_adjacency_matrix_defines.svh.
`include "dfs_timestamps_adjacency_matrix_defines.svh"

module dfsta_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dfsta_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tlast
);

    logic last_ok;

    // A marked result must carry the highest vertex index.
    assign last_ok = !m_tlast || (m_tdata[dfsta_pkg::VIDX_W-1:0] == dfsta_pkg::LAST_VERTEX);

    // A held result stays valid and unchanged until taken.
    `DFSTA_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `DFSTA_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed")

    // A run transaction makes the block busy in the next cycle.
    `DFSTA_ASSERT(a_run_busy, s_tvalid && s_tready && s_tuser |=> !s_tready, "busy expected")

    // The final result of a run describes the highest vertex.
    `DFSTA_ASSERT(a_last_vertex, m_tvalid |-> last_ok, "tlast on wrong vertex")

    // Nothing is offered in the cycle after a reset cycle.
    `DFSTA_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind dfs_timestamps_adjacency_matrix dfsta_checker u_dfsta_checker (.*);

>>> test/dfs_timestamps_adjacency_matrix_test.sv
// Self-checking testbench for the depth-first search block: loads adjacency rows, runs
// searches and checks every vertex result against a search predictor or golden results.
// Depends on dfsta_pkg and dfs_timestamps_adjacency_matrix.
module dfs_timestamps_adjacency_matrix_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 86;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 120;
    localparam int REPORT_MAX   = 10;

    // Expected results that can be read straight off the graph shape.
    typedef enum logic [1:0] {
        GOLD_NONE,
        GOLD_NO_EDGES,
        GOLD_CHAIN
    } golden_t;

    typedef struct {
        logic       func;
        logic [2:0] row;
        logic [7:0] edges;
        golden_t    golden;
    } stim_t;

    // One result transaction, in the order of the fields on m_tdata.
    typedef struct packed {
        logic [2:0] vertex;
        logic       has_parent;
        logic [2:0] parent;
        logic [4:0] discover;
        logic [4:0] finish;
        logic       last;
    } vertex_result_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [dfsta_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                            s_tuser  = dfsta_pkg::FUNC_LOAD;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [dfsta_pkg::M_TDATA_W-1:0] m_tdata;
    logic                            m_tlast;

    // Predictor state and bookkeeping.
    logic [7:0]     graph_rows [dfsta_pkg::NODES];
    vertex_result_t expected_vertex_results [$];
    bit             no_idle         = 1'b0;
    int             sink_hold       = 0;
    int             cycle_count     = 0;
    int             mismatch_count  = 0;
    int             results_checked = 0;
    int             loads_sent      = 0;
    int             runs_sent       = 0;
    int             random_items    = 0;

    // Short directed sequence: empty graph, repeated run, complete graph, self edges.
    stim_t directed_table [24] = '{
        '{dfsta_pkg::FUNC_LOAD, 3'd0, 8'h00, GOLD_NONE},
        '{dfsta_pkg::FUNC_LOAD, 3'd1, 8'h00, GOLD_NONE},
        '{dfsta_pkg::FUNC_LOAD, 3'd2, 8'h00, GOLD_NONE},
        '{dfsta_pkg::FUNC_LOAD, 3'd3, 8'h00, GOLD_NONE},
        '{dfsta_pkg::FUNC_LOAD, 3'd4, 8'h00, GOLD_NONE},
        '{dfsta_pkg::FUNC_LOAD, 3'd5, 8'h00, GOLD_NONE},
        '{dfsta_pkg::FUNC_LOAD, 3'd6, 8'h00, GOLD_NONE},
        '{dfsta_pkg::FUNC_LOAD, 3'd7, 8'h00, GOLD_NONE},
        '{dfsta_pkg::FUNC_RUN,  3'd0, 8'h00, GOLD_NO_EDGES},
        '{dfsta_pkg::FUNC_RUN,  3'd7, 8'hFF, GOLD_NO_EDGES},
        '{dfsta_pkg::FUNC_LOAD, 3'd0, 8'hFF, GOLD_NONE},
        '{dfsta_pkg::FUNC_LOAD, 3'd1, 8'hFF, GOLD_NONE},
        '{dfsta_pkg::FUNC_LOAD, 3'd2, 8'hFF, GOLD_NONE},
        '{dfsta_pkg::FUNC_LOAD, 3'd3, 8'hFF, GOLD_NONE},
        '{dfsta_pkg::FUNC_LOAD, 3'd4, 8'hFF, GOLD_NONE},
        '{dfsta_pkg::FUNC_LOAD, 3'd5, 8'hFF, GOLD_NONE},
        '{dfsta_pkg::FUNC_LOAD, 3'd6, 8'hFF, GOLD_NONE},
        '{dfsta_pkg::FUNC_LOAD, 3'd7, 8'hFF, GOLD_NONE},
        '{dfsta_pkg::FUNC_RUN,  3'd0, 8'h00, GOLD_CHAIN},
        '{dfsta_pkg::FUNC_LOAD, 3'd0, 8'h01, GOLD_NONE},
        '{dfsta_pkg::FUNC_RUN,  3'd0, 8'h00, GOLD_NONE},
        '{dfsta_pkg::FUNC_LOAD, 3'd7, 8'h80, GOLD_NONE},
        '{dfsta_pkg::FUNC_LOAD, 3'd3, 8'h01, GOLD_NONE},
        '{dfsta_pkg::FUNC_RUN,  3'd5, 8'hA5, GOLD_NONE}
    };

    dfs_timestamps_adjacency_matrix u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Free-running clock, 10 ns period.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_vertex_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Idle cycles before the next transaction on either side.
    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 10));
    endfunction

    // Edge rows of varied density so that both shallow and deep searches occur.
    function automatic logic [7:0] draw_edges();
        logic [7:0] edges;
        case ($urandom_range(0, 5))
            0: edges = 8'($urandom());
            1: edges = 8'($urandom() & $urandom());
            2: edges = 8'($urandom() | $urandom());
            3: edges = 8'h01 << $urandom_range(0, 7);
            4: edges = 8'($urandom() & $urandom() & $urandom());
            default: edges = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
        endcase
        return edges;
    endfunction

    // Results for graphs whose search order is obvious: no edges, or every edge.
    function automatic vertex_result_t golden_result(input golden_t kind, input int k);
        vertex_result_t res;
        res.vertex = 3'(k);
        res.last   = (k == dfsta_pkg::NODES - 1);
        if (kind == GOLD_CHAIN) begin
            res.has_parent = (k != 0);
            res.parent     = (k != 0) ? 3'(k - 1) : 3'd0;
            res.discover   = 5'(k + 1);
            res.finish     = 5'(2 * dfsta_pkg::NODES - k);
        end else begin
            res.has_parent = 1'b0;
            res.parent     = 3'd0;
            res.discover   = 5'(2 * k + 1);
            res.finish     = 5'(2 * k + 2);
        end
        return res;
    endfunction

    // Full depth-first search over graph_rows; queues one result per vertex.
    task automatic predict_search();
        dfsta_pkg::colour_t colour [dfsta_pkg::NODES];
        logic [2:0] par      [dfsta_pkg::NODES];
        logic       par_ok   [dfsta_pkg::NODES];
        logic [4:0] t_disc   [dfsta_pkg::NODES];
        logic [4:0] t_fin    [dfsta_pkg::NODES];
        logic [2:0] stk_v    [dfsta_pkg::NODES];
        int         stk_pos  [dfsta_pkg::NODES];
        logic [4:0] tick;
        vertex_result_t res;
        int depth, top, v, m;
        for (int k = 0; k < dfsta_pkg::NODES; k++) begin
            colour[k] = dfsta_pkg::CLR_WHITE;
            par[k]    = 3'd0;
            par_ok[k] = 1'b0;
            t_disc[k] = 5'd0;
            t_fin[k]  = 5'd0;
        end
        tick  = 5'd0;
        depth = 0;
        for (int r = 0; r < dfsta_pkg::NODES; r++) begin
            if (colour[r] != dfsta_pkg::CLR_WHITE) continue;
            tick      = tick + 5'd1;
            t_disc[r] = tick;
            colour[r] = dfsta_pkg::CLR_GREY;
            stk_v[0]   = 3'(r);
            stk_pos[0] = 0;
            depth      = 1;
            while (depth > 0) begin
                top = depth - 1;
                v   = stk_v[top];
                // Next white neighbor at or after the saved scan position.
                for (m = stk_pos[top]; m < dfsta_pkg::NODES; m++) begin
                    if (graph_rows[v][m] && colour[m] == dfsta_pkg::CLR_WHITE) break;
                end
                if (m < dfsta_pkg::NODES && depth < dfsta_pkg::NODES) begin
                    stk_pos[top] = m + 1;
                    par[m]       = 3'(v);
                    par_ok[m]    = 1'b1;
                    tick         = tick + 5'd1;
                    t_disc[m]    = tick;
                    colour[m]    = dfsta_pkg::CLR_GREY;
                    stk_v[depth]   = 3'(m);
                    stk_pos[depth] = 0;
                    depth++;
                end else begin
                    colour[v] = dfsta_pkg::CLR_BLACK;
                    tick      = tick + 5'd1;
                    t_fin[v]  = tick;
                    depth--;
                end
            end
        end
        for (int k = 0; k < dfsta_pkg::NODES; k++) begin
            res.vertex     = 3'(k);
            res.has_parent = par_ok[k];
            res.parent     = par_ok[k] ? par[k] : 3'd0;
            res.discover   = t_disc[k];
            res.finish     = t_fin[k];
            res.last       = (k == dfsta_pkg::NODES - 1);
            expected_vertex_results.push_back(res);
        end
    endtask

    // Updates the predictor once an input transaction has been accepted.
    task automatic record_accepted(input stim_t it);
        if (it.func == dfsta_pkg::FUNC_LOAD) begin
            graph_rows[it.row] = it.edges;
            loads_sent++;
        end else begin
            runs_sent++;
            if (it.golden != GOLD_NONE) begin
                for (int k = 0; k < dfsta_pkg::NODES; k++) begin
                    expected_vertex_results.push_back(golden_result(it.golden, k));
                end
            end else begin
                predict_search();
            end
        end
    endtask

    // Drives one input transaction, after a random gap, and waits for acceptance.
    task automatic send_item(input stim_t it);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= dfsta_pkg::S_TDATA_W'({it.edges, it.row});
        do @(posedge aclk); while (!s_tready);
        record_accepted(it);
    endtask

    task automatic send_random(input logic func, input logic [2:0] row);
        stim_t it;
        it.func   = func;
        it.row    = row;
        it.edges  = draw_edges();
        it.golden = GOLD_NONE;
        send_item(it);
        random_items++;
    endtask

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) $display("MISMATCH: %s", msg);
    endtask

    // Compares one result transaction with the oldest expectation.
    task automatic check_vertex_result(input vertex_result_t got);
        vertex_result_t want;
        if (expected_vertex_results.size() == 0) begin
            note_failure($sformatf("result for vertex %0d with none expected", got.vertex));
            return;
        end
        want = expected_vertex_results.pop_front();
        results_checked++;
        if (got.vertex !== want.vertex || got.has_parent !== want.has_parent ||
            got.parent !== want.parent || got.discover !== want.discover ||
            got.finish !== want.finish || got.last !== want.last) begin
            note_failure($sformatf(
                {"expected v=%0d hp=%0b p=%0d d=%0d f=%0d last=%0b, ",
                 "got v=%0d hp=%0b p=%0d d=%0d f=%0d last=%0b"},
                want.vertex, want.has_parent, want.parent, want.discover, want.finish,
                want.last, got.vertex, got.has_parent, got.parent, got.discover,
                got.finish, got.last));
        end
    endtask

    // Result side: check each accepted transaction, then stall for a random while.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_vertex_result({m_tdata[2:0], m_tdata[3], m_tdata[6:4],
                                     m_tdata[11:7], m_tdata[16:12], m_tlast});
                sink_hold = draw_wait();
            end
            if (sink_hold > 0) begin
                m_tready <= 1'b0;
                sink_hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Main sequence: reset, directed table, random graphs, drain and verdict.
    initial begin
        int kind;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_table[i]) begin
            send_item(directed_table[i]);
        end

        // Mostly whole graphs followed by a run; some edits and back-to-back runs.
        while (random_items < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            kind    = $urandom_range(0, 3);
            case (kind)
                0, 1: begin
                    for (int v = 0; v < dfsta_pkg::NODES; v++) begin
                        send_random(dfsta_pkg::FUNC_LOAD, 3'(v));
                    end
                    send_random(dfsta_pkg::FUNC_RUN, 3'($urandom_range(0, 7)));
                end
                2: begin
                    repeat ($urandom_range(1, 3)) begin
                        send_random(dfsta_pkg::FUNC_LOAD, 3'($urandom_range(0, 7)));
                    end
                    send_random(dfsta_pkg::FUNC_RUN, 3'($urandom_range(0, 7)));
                end
                default: begin
                    send_random(dfsta_pkg::FUNC_LOAD, 3'($urandom_range(0, 7)));
                    send_random(dfsta_pkg::FUNC_RUN, 3'($urandom_range(0, 7)));
                    send_random(dfsta_pkg::FUNC_RUN, 3'($urandom_range(0, 7)));
                end
            endcase
        end
        s_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (expected_vertex_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d searches over %0d row loads.", runs_sent, loads_sent);
        $display("Checked %0d vertex results, %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
